FILE: hw/rtl/pcpg_pkg.sv
// Shared constants, types and fixed-point helpers of the curve point generator.
package pcpg_pkg;

    localparam int PHASE_BITS      = 12;
    localparam int COORD_FRAC_BITS = 14;
    localparam int PIXEL_BITS      = 12;
    localparam int MAX_STEPS_LOG2  = 10;

    localparam int SHAPE_W  = 3;
    localparam int SCALE_W  = 8;
    localparam int STEPS_W  = 4;
    localparam int CENTER_W = 12;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    localparam int QUARTER = 1 << (PHASE_BITS - 2);
    localparam int ROM_AW  = PHASE_BITS - 1;
    localparam int MAG_W   = COORD_FRAC_BITS + 1;
    localparam int SINE_W  = COORD_FRAC_BITS + 2;
    localparam int COORD_W = COORD_FRAC_BITS + 8;
    localparam int PX_W    = COORD_W + 10;

    localparam int CYC_W = 33;
    // 3 * 2pi in Q28
    localparam logic [CYC_W-1:0] CYC_Q28 = 33'd5059889139;

    localparam logic signed [COORD_W-1:0] FX_ONE = COORD_W'(1 << COORD_FRAC_BITS);
    localparam logic signed [COORD_W-1:0] FX_1P5 = COORD_W'(3 << (COORD_FRAC_BITS - 1));
    localparam logic [2*COORD_W-1:0] FX_HALF = (2*COORD_W)'(1 << (COORD_FRAC_BITS - 1));
    localparam int PIX_MAX = (1 << PIXEL_BITS) - 1;

    typedef logic [MAG_W-1:0] sine_table_t [0:QUARTER];

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_ASTROID = 3'd0,
        SHAPE_CYCLOID = 3'd1,
        SHAPE_HUYGENS = 3'd2,
        SHAPE_HYPO    = 3'd3,
        SHAPE_LINE    = 3'd4
    } shape_t;

    typedef enum logic [2:0] {
        CFG_SHAPE    = 3'd0,
        CFG_SCALE    = 3'd1,
        CFG_STEPS    = 3'd2,
        CFG_CENTER_X = 3'd3,
        CFG_CENTER_Y = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pix;
        logic                  clip;
    } pix_res_t;

    // Quarter-wave sine, odd degree-9 polynomial in Q30, rounded to the coordinate format.
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] q;
        for (int i = 0; i <= QUARTER; i++)
        begin
            x  = 64'(i) << (30 - (PHASE_BITS - 2));
            x2 = (x * x) >> 30;
            p  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
            p  = 64'd85569306 - ((x2 * p) >> 30);
            p  = 64'd693598668 - ((x2 * p) >> 30);
            p  = 64'd1686629713 - ((x2 * p) >> 30);
            r  = (x * p) >> 30;
            q  = (r + (64'd1 << (29 - COORD_FRAC_BITS))) >> (30 - COORD_FRAC_BITS);
            if (q > 64'(1 << COORD_FRAC_BITS))
            begin
                q = 64'(1 << COORD_FRAC_BITS);
            end
            tbl[i] = q[MAG_W-1:0];
        end
        return tbl;
    endfunction

    // Signed fixed-point product, rounded to nearest with ties away from zero.
    function automatic logic signed [COORD_W-1:0] fx_mul(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic                   neg;
        logic [COORD_W-1:0]     ua;
        logic [COORD_W-1:0]     ub;
        logic [2*COORD_W-1:0]   m;
        neg = a[COORD_W-1] ^ b[COORD_W-1];
        ua  = a[COORD_W-1] ? -a : a;
        ub  = b[COORD_W-1] ? -b : b;
        m   = (2*COORD_W)'(ua) * (2*COORD_W)'(ub) + FX_HALF;
        m   = m >> COORD_FRAC_BITS;
        return neg ? -$signed(m[COORD_W-1:0]) : $signed(m[COORD_W-1:0]);
    endfunction

endpackage

FILE: hw/rtl/pcpg_sine_rom.sv
// Quarter-wave sine ROM with quadrant folding and registered read.
module pcpg_sine_rom (
    input  logic                                  clk,
    input  logic [pcpg_pkg::PHASE_BITS-1:0]       phase,
    output logic signed [pcpg_pkg::SINE_W-1:0]    value
);
    import pcpg_pkg::*;

    localparam sine_table_t SINE_ROM = build_sine_table();

    logic [1:0]              quad;
    logic [PHASE_BITS-3:0]   frac;
    logic [ROM_AW-1:0]       addr;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;

    always_comb
    begin
        quad = phase[PHASE_BITS-1:PHASE_BITS-2];
        frac = phase[PHASE_BITS-3:0];
        if (quad[0])
        begin
            addr = ROM_AW'(QUARTER) - {1'b0, frac};
        end
        else
        begin
            addr = {1'b0, frac};
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= SINE_ROM[addr];
        neg_reg <= quad[1];
    end

    assign value = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

FILE: hw/rtl/parametric_curve_point_generator.sv
// Parametric curve point generator: seven-stage pipeline with an APB register port.
// done is the valid bit of the taken start after the seventh stage and comes with that start's result.
// Throughput: one point per clock; busy is always low and the pipeline never stalls.
// The depth is set by two chained fixed-point multiplies, the sine ROM read and pixel mapping.
// Reset clears the valid pipeline and loads the register defaults (shape 0, scale 40,
// steps_log2 8, center 199/199); results in flight are dropped.
module parametric_curve_point_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [pcpg_pkg::MAX_STEPS_LOG2-1:0] step_index,
    output logic                                done,
    output logic [pcpg_pkg::PIXEL_BITS-1:0]     pixel_x,
    output logic [pcpg_pkg::PIXEL_BITS-1:0]     pixel_y,
    output logic                                clipped,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pcpg_pkg::APB_AW-1:0]         paddr,
    input  logic [pcpg_pkg::APB_DW-1:0]         pwdata,
    output logic [pcpg_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);
    import pcpg_pkg::*;

    localparam int KW   = MAX_STEPS_LOG2;
    localparam int CPW  = KW + CYC_W + 1;
    localparam int NSTG = 7;
    localparam logic signed [PX_W-1:0] NEG_ONE_PX = PX_W'(-(1 << COORD_FRAC_BITS));

    // configuration
    logic [SHAPE_W-1:0]  shape_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [STEPS_W-1:0]  steps_reg;
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic                cfg_wr;
    logic [STEPS_W-1:0]  s_eff;

    // pipeline
    logic [NSTG-1:0]     vld_reg;
    logic [NSTG-1:0]     vld_next;

    logic [KW-1:0]       k1_reg;
    logic [KW-1:0]       k1_next;

    logic [KW+1:0]       kt;
    logic [KW+1+PHASE_BITS:0] phw;
    logic [KW+COORD_FRAC_BITS-1:0] tlw;
    logic [PHASE_BITS-1:0] ph1;
    logic [PHASE_BITS-1:0] ph2;
    logic [PHASE_BITS-1:0] ph1s_reg;
    logic [PHASE_BITS-1:0] ph1c_reg;
    logic [PHASE_BITS-1:0] ph2s_reg;
    logic [PHASE_BITS-1:0] ph2c_reg;
    logic [KW+CYC_W-1:0]   prod2_reg;
    logic [KW+CYC_W-1:0]   prod2_next;
    logic [COORD_FRAC_BITS-1:0] tline2_reg;

    logic [KW+CYC_W-1:0]   prod3_reg;
    logic [COORD_FRAC_BITS-1:0] tline3_reg;
    logic signed [SINE_W-1:0] sin1;
    logic signed [SINE_W-1:0] cos1;
    logic signed [SINE_W-1:0] sin2;
    logic signed [SINE_W-1:0] cos2;

    logic signed [COORD_W-1:0] s1;
    logic signed [COORD_W-1:0] c1;
    logic signed [COORD_W-1:0] s2;
    logic signed [COORD_W-1:0] c2;
    logic signed [COORD_W-1:0] c_sq;
    logic signed [COORD_W-1:0] s_sq;
    logic signed [COORD_W-1:0] t_cyc;
    logic signed [COORD_W-1:0] t_line;
    logic [4:0]                sh;
    logic [CPW-1:0]            tc_full;
    logic signed [COORD_W-1:0] ax_next;
    logic signed [COORD_W-1:0] bx_next;
    logic signed [COORD_W-1:0] ay_next;
    logic signed [COORD_W-1:0] by_next;
    logic signed [COORD_W-1:0] ax_reg;
    logic signed [COORD_W-1:0] bx_reg;
    logic signed [COORD_W-1:0] ay_reg;
    logic signed [COORD_W-1:0] by_reg;

    logic signed [COORD_W-1:0] x_next;
    logic signed [COORD_W-1:0] y_next;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;

    logic signed [PX_W-1:0]    px_next;
    logic signed [PX_W-1:0]    py_next;
    logic signed [PX_W-1:0]    px_reg;
    logic signed [PX_W-1:0]    py_reg;

    pix_res_t                  rx;
    pix_res_t                  ry;
    logic [PIXEL_BITS-1:0]     pixel_x_reg;
    logic [PIXEL_BITS-1:0]     pixel_y_reg;
    logic                      clipped_reg;

    function automatic pix_res_t to_pixel(input logic signed [PX_W-1:0] p);
        pix_res_t                     r;
        logic [PX_W-COORD_FRAC_BITS-1:0] whole;
        whole = p[PX_W-1:COORD_FRAC_BITS];
        if (p[PX_W-1])
        begin
            r.pix  = '0;
            r.clip = (p <= NEG_ONE_PX);
        end
        else if (whole > (PX_W-COORD_FRAC_BITS)'(PIX_MAX))
        begin
            r.pix  = '1;
            r.clip = 1'b1;
        end
        else
        begin
            r.pix  = whole[PIXEL_BITS-1:0];
            r.clip = 1'b0;
        end
        return r;
    endfunction

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg    <= '0;
            scale_reg    <= 8'd40;
            steps_reg    <= 4'd8;
            center_x_reg <= 12'd199;
            center_y_reg <= 12'd199;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                CFG_SHAPE:    shape_reg    <= pwdata[SHAPE_W-1:0];
                CFG_SCALE:    scale_reg    <= pwdata[SCALE_W-1:0];
                CFG_STEPS:    steps_reg    <= pwdata[STEPS_W-1:0];
                CFG_CENTER_X: center_x_reg <= pwdata[CENTER_W-1:0];
                CFG_CENTER_Y: center_y_reg <= pwdata[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            CFG_SHAPE:    prdata = APB_DW'(shape_reg);
            CFG_SCALE:    prdata = APB_DW'(scale_reg);
            CFG_STEPS:    prdata = APB_DW'(steps_reg);
            CFG_CENTER_X: prdata = APB_DW'(center_x_reg);
            CFG_CENTER_Y: prdata = APB_DW'(center_y_reg);
            default:      prdata = '0;
        endcase
    end

    assign s_eff = (steps_reg > STEPS_W'(MAX_STEPS_LOG2)) ? STEPS_W'(MAX_STEPS_LOG2) : steps_reg;

    // ---------------- valid chain ----------------
    assign vld_next = {vld_reg[NSTG-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------- stage 1: index capture ----------------
    assign k1_next = step_index & ~({KW{1'b1}} << s_eff);

    always_ff @(posedge clk)
    begin
        k1_reg <= k1_next;
    end

    // ---------------- stage 2: phases and parameter terms ----------------
    always_comb
    begin
        case (shape_reg)
            SHAPE_CYCLOID: kt = {2'b00, k1_reg} + {1'b0, k1_reg, 1'b0};
            SHAPE_HUYGENS: kt = {1'b0, k1_reg, 1'b0};
            default:       kt = {2'b00, k1_reg};
        endcase
        phw = {kt, PHASE_BITS'(0)} >> s_eff;
        ph1 = phw[PHASE_BITS-1:0];
        if (shape_reg == SHAPE_HUYGENS)
        begin
            ph2 = ph1 + (ph1 << 1);
        end
        else
        begin
            ph2 = ph1 << 1;
        end
        tlw        = {k1_reg, COORD_FRAC_BITS'(0)} >> s_eff;
        prod2_next = (KW+CYC_W)'(k1_reg) * CYC_Q28;
    end

    always_ff @(posedge clk)
    begin
        ph1s_reg   <= ph1;
        ph1c_reg   <= ph1 + PHASE_BITS'(QUARTER);
        ph2s_reg   <= ph2;
        ph2c_reg   <= ph2 + PHASE_BITS'(QUARTER);
        prod2_reg  <= prod2_next;
        tline2_reg <= tlw[COORD_FRAC_BITS-1:0];
    end

    // ---------------- stage 3: sine lookups ----------------
    pcpg_sine_rom u_sin1 (.clk(clk), .phase(ph1s_reg), .value(sin1));
    pcpg_sine_rom u_cos1 (.clk(clk), .phase(ph1c_reg), .value(cos1));
    pcpg_sine_rom u_sin2 (.clk(clk), .phase(ph2s_reg), .value(sin2));
    pcpg_sine_rom u_cos2 (.clk(clk), .phase(ph2c_reg), .value(cos2));

    always_ff @(posedge clk)
    begin
        prod3_reg  <= prod2_reg;
        tline3_reg <= tline2_reg;
    end

    // ---------------- stage 4: curve terms ----------------
    always_comb
    begin
        s1 = {{(COORD_W-SINE_W){sin1[SINE_W-1]}}, sin1};
        c1 = {{(COORD_W-SINE_W){cos1[SINE_W-1]}}, cos1};
        s2 = {{(COORD_W-SINE_W){sin2[SINE_W-1]}}, sin2};
        c2 = {{(COORD_W-SINE_W){cos2[SINE_W-1]}}, cos2};
        c_sq = fx_mul(c1, c1);
        s_sq = fx_mul(s1, s1);
        sh      = 5'(s_eff) + 5'(28 - COORD_FRAC_BITS);
        tc_full = ({1'b0, prod3_reg} + (CPW'(1) << (sh - 5'd1))) >> sh;
        t_cyc   = $signed(tc_full[COORD_W-1:0]);
        t_line  = $signed(COORD_W'(tline3_reg));
        case (shape_reg)
            SHAPE_ASTROID:
            begin
                ax_next = c_sq;
                bx_next = c1;
                ay_next = s_sq;
                by_next = s1;
            end
            SHAPE_CYCLOID:
            begin
                ax_next = FX_ONE - c1;
                bx_next = FX_1P5;
                ay_next = t_cyc - s1;
                by_next = FX_1P5;
            end
            SHAPE_HUYGENS:
            begin
                ax_next = ((c1 <<< 1) + c1 - c2) <<< 2;
                bx_next = FX_ONE;
                ay_next = ((s1 <<< 1) + s1 - s2) <<< 2;
                by_next = FX_ONE;
            end
            SHAPE_HYPO:
            begin
                ax_next = (c1 <<< 1) + c2;
                bx_next = FX_1P5;
                ay_next = (s1 <<< 1) - s2;
                by_next = FX_1P5;
            end
            SHAPE_LINE:
            begin
                ax_next = FX_ONE - t_line;
                bx_next = FX_ONE;
                ay_next = FX_ONE - t_line;
                by_next = FX_ONE;
            end
            default:
            begin
                ax_next = '0;
                bx_next = FX_ONE;
                ay_next = '0;
                by_next = FX_ONE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ax_reg <= ax_next;
        bx_reg <= bx_next;
        ay_reg <= ay_next;
        by_reg <= by_next;
    end

    // ---------------- stage 5: final coordinate product ----------------
    always_comb
    begin
        x_next = fx_mul(ax_reg, bx_reg);
        y_next = fx_mul(ay_reg, by_reg);
        if (shape_reg == SHAPE_ASTROID)
        begin
            x_next = x_next <<< 1;
            y_next = y_next <<< 1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    // ---------------- stage 6: scale and offset ----------------
    always_comb
    begin
        px_next = {{(PX_W-COORD_W){x_reg[COORD_W-1]}}, x_reg} * $signed(PX_W'(scale_reg))
                + $signed(PX_W'({center_x_reg, COORD_FRAC_BITS'(0)}));
        py_next = {{(PX_W-COORD_W){y_reg[COORD_W-1]}}, y_reg} * $signed(PX_W'(scale_reg))
                + $signed(PX_W'({center_y_reg, COORD_FRAC_BITS'(0)}));
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
    end

    // ---------------- stage 7: truncate and saturate ----------------
    assign rx = to_pixel(px_reg);
    assign ry = to_pixel(py_reg);

    always_ff @(posedge clk)
    begin
        pixel_x_reg <= rx.pix;
        pixel_y_reg <= ry.pix;
        clipped_reg <= rx.clip | ry.clip;
    end

    assign done    = vld_reg[NSTG-1];
    assign pixel_x = pixel_x_reg;
    assign pixel_y = pixel_y_reg;
    assign clipped = clipped_reg;

endmodule
